/* hw/rtl/ove_pkg.sv */
// ----------------------------------------------------------------------------
// ove_pkg
// Shared types and constants for the object velocity estimator.
// ----------------------------------------------------------------------------
package ove_pkg;

  // Microseconds per second, scales a position difference into a velocity
  localparam logic [19:0] US_PER_S = 20'd1000000;

  // Reset value of the speed limit register
  localparam logic [31:0] SPEED_LIMIT_RST = 32'd800;

  // Input opcodes
  localparam logic OP_DETECT = 1'b0;
  localparam logic OP_CLOSE  = 1'b1;

  // Operation of the shared iterative unit
  typedef enum logic {
    ITU_DIV  = 1'b0,
    ITU_SQRT = 1'b1
  } itu_mode_e;

  // Request to the iterative unit
  typedef struct packed {
    logic      start;
    itu_mode_e mode;
  } itu_req_t;

  // Status from the iterative unit
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } itu_rsp_t;

endpackage

/* hw/rtl/object_velocity_estimator.sv */
// ----------------------------------------------------------------------------
// object_velocity_estimator
// Finite-difference velocity and speed of numbered objects across frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one detection or close-frame
//   transaction. in_stall_o stays high while an item is in work.
//   Output channel (out_valid_o / out_stall_i): one result per item, held
//   in an output register, so a stalled result does not block the next input.
//   Config channel (cfg_valid_i / cfg_ready_o): writes speed_limit, always
//   ready; write only while the block is idle.
// Sequence: a close, an out-of-range id, an unseen object or a zero interval
//   goes from accept through S_DIFF and S_FIN into the output register. A
//   measured detection runs S_DIFF, S_MUL, S_DIVS and S_DIVW for each of the
//   three divides, S_SQM and S_SQA for each of the three squares, then S_SQRTS
//   and S_SQRTW for the square root and S_FIN, on the 32-step shared divide
//   and square root unit. A stalled result holds the finish step.
// Reset: seen bits, frame flag and speed limit (800) reset; position stores
//   are undefined until written.
// ----------------------------------------------------------------------------
module object_velocity_estimator
  import ove_pkg::*;
#(
  parameter int NUM_OBJECTS = 5,
  parameter int POS_WIDTH   = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [2:0]                  object_id_i,
  input  logic signed [POS_WIDTH-1:0] pos_x_i,
  input  logic signed [POS_WIDTH-1:0] pos_y_i,
  input  logic signed [POS_WIDTH-1:0] pos_z_i,
  input  logic [19:0]                 interval_us_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  out_id_o,
  output logic                        is_close_o,
  output logic                        vel_valid_o,
  output logic signed [31:0]          vel_x_o,
  output logic signed [31:0]          vel_y_o,
  output logic signed [31:0]          vel_z_o,
  output logic [31:0]                 speed_o,
  output logic                        frame_state_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [31:0]                 cfg_data_i
);

  localparam int IDX_W = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int IDE_W = (IDX_W > 3) ? IDX_W : 3;
  localparam int MAG_W = POS_WIDTH + 1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DIFF   = 10'b00_0000_0010,
    S_MUL    = 10'b00_0000_0100,
    S_DIVS   = 10'b00_0000_1000,
    S_DIVW   = 10'b00_0001_0000,
    S_SQM    = 10'b00_0010_0000,
    S_SQA    = 10'b00_0100_0000,
    S_SQRTS  = 10'b00_1000_0000,
    S_SQRTW  = 10'b01_0000_0000,
    S_FIN    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Latched input item
  logic                        op_q;
  logic [2:0]                  id_q;
  logic signed [POS_WIDTH-1:0] px_q, py_q, pz_q;
  logic [19:0]                 iv_q;

  // Object state
  logic signed [POS_WIDTH-1:0] cur_x_q [NUM_OBJECTS];
  logic signed [POS_WIDTH-1:0] cur_y_q [NUM_OBJECTS];
  logic signed [POS_WIDTH-1:0] cur_z_q [NUM_OBJECTS];
  logic signed [POS_WIDTH-1:0] prev_x_q [NUM_OBJECTS];
  logic signed [POS_WIDTH-1:0] prev_y_q [NUM_OBJECTS];
  logic signed [POS_WIDTH-1:0] prev_z_q [NUM_OBJECTS];
  logic [NUM_OBJECTS-1:0]      cur_seen_q;
  logic [NUM_OBJECTS-1:0]      prev_seen_q;
  logic                        any_valid_q;
  logic [31:0]                 speed_limit_q;

  // Work registers
  logic [1:0]         ax_q;
  logic [MAG_W-1:0]   mag_q;
  logic               neg_q;
  logic [63:0]        prod_q;
  logic [63:0]        sum_q;
  logic signed [31:0] vel_q [3];
  logic [31:0]        speed_q;

  // Output register
  logic               out_valid_q;
  logic [2:0]         out_id_q;
  logic               is_close_q;
  logic               vel_valid_q;
  logic signed [31:0] vel_x_q, vel_y_q, vel_z_q;
  logic [31:0]        speed_out_q;
  logic               frame_state_q;

  logic [IDE_W-1:0]            id_ext;
  logic [IDX_W-1:0]            idx;
  logic                        in_range;
  logic                        calc;
  logic                        in_fire;
  logic                        fin_fire;
  logic                        meas_ok;
  logic signed [POS_WIDTH-1:0] pos_sel, prev_sel;
  logic signed [MAG_W-1:0]     d;
  logic signed [31:0]          vel_sel;
  logic [31:0]                 abs_v;
  logic [32:0]                 mul_a;
  logic [31:0]                 mul_b;
  logic [64:0]                 mul_p;
  logic [31:0]                 q;
  logic signed [31:0]          sat_v;

  itu_req_t    itu_req;
  itu_rsp_t    itu_rsp;
  logic [63:0] itu_num;
  logic [31:0] itu_res;

  // Decode the latched item
  assign id_ext   = IDE_W'(id_q);
  assign idx      = id_ext[IDX_W-1:0];
  assign in_range = {29'd0, id_q} < 32'(NUM_OBJECTS);
  assign calc     = (op_q == OP_DETECT) && in_range && prev_seen_q[idx] && (iv_q != 20'd0);
  assign in_fire  = in_valid_i && !in_stall_o;
  assign fin_fire = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign meas_ok  = calc && (speed_q < speed_limit_q);

  // Pick the axis in work
  always_comb begin
    unique case (ax_q)
      2'd0: begin
        pos_sel  = px_q;
        prev_sel = prev_x_q[idx];
      end
      2'd1: begin
        pos_sel  = py_q;
        prev_sel = prev_y_q[idx];
      end
      default: begin
        pos_sel  = pz_q;
        prev_sel = prev_z_q[idx];
      end
    endcase
    d       = {pos_sel[POS_WIDTH-1], pos_sel} - {prev_sel[POS_WIDTH-1], prev_sel};
    vel_sel = vel_q[ax_q];
    abs_v   = vel_sel[31] ? (~vel_sel + 32'd1) : vel_sel;
  end

  // Shared multiplier: difference times 1e6, or velocity squared
  always_comb begin
    if (state_q == S_MUL) begin
      mul_a = 33'(mag_q);
      mul_b = {12'd0, US_PER_S};
    end else begin
      mul_a = {1'b0, abs_v};
      mul_b = abs_v;
    end
    mul_p = mul_a * mul_b;
  end

  // Saturate the quotient to a signed 32 bit velocity
  always_comb begin
    q = itu_res;
    if (neg_q) begin
      sat_v = (itu_rsp.ovf || (q > 32'h8000_0000)) ? 32'sh8000_0000 : (~q + 32'd1);
    end else begin
      sat_v = (itu_rsp.ovf || q[31]) ? 32'sh7FFF_FFFF : q;
    end
  end

  // Drive the iterative unit
  always_comb begin
    itu_req.start = (state_q == S_DIVS) || (state_q == S_SQRTS);
    itu_req.mode  = (state_q == S_SQRTS) ? ITU_SQRT : ITU_DIV;
    itu_num       = (state_q == S_SQRTS) ? sum_q : prod_q;
  end

  ove_itu u_itu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (itu_req),
    .num_i  (itu_num),
    .den_i  (iv_q),
    .rsp_o  (itu_rsp),
    .res_o  (itu_res)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_DIFF;
      S_DIFF:  state_d = calc ? S_MUL : S_FIN;
      S_MUL:   state_d = S_DIVS;
      S_DIVS:  state_d = S_DIVW;
      S_DIVW: begin
        if (itu_rsp.done) state_d = (ax_q == 2'd2) ? S_SQM : S_DIFF;
      end
      S_SQM:   state_d = S_SQA;
      S_SQA:   state_d = (ax_q == 2'd2) ? S_SQRTS : S_SQM;
      S_SQRTS: state_d = S_SQRTW;
      S_SQRTW: if (itu_rsp.done) state_d = S_FIN;
      S_FIN:   if (fin_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the item and run the arithmetic
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= opcode_i;
      id_q <= object_id_i;
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
      iv_q <= interval_us_i;
      ax_q <= 2'd0;
    end
    unique case (state_q)
      S_DIFF: begin
        neg_q <= d[MAG_W-1];
        mag_q <= d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
      end
      S_MUL: prod_q <= mul_p[63:0];
      S_DIVW: begin
        if (itu_rsp.done) begin
          vel_q[ax_q] <= sat_v;
          ax_q        <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
        end
      end
      S_SQM: prod_q <= mul_p[63:0];
      S_SQA: begin
        sum_q <= ((ax_q == 2'd0) ? 64'd0 : sum_q) + prod_q;
        ax_q  <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
      end
      S_SQRTW: if (itu_rsp.done) speed_q <= itu_res;
      default: ;
    endcase
  end

  // Update object stores at the end of an item
  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      if (op_q == OP_CLOSE) begin
        if (cur_seen_q != '0) begin
          prev_x_q <= cur_x_q;
          prev_y_q <= cur_y_q;
          prev_z_q <= cur_z_q;
        end
      end else if (in_range) begin
        cur_x_q[idx] <= px_q;
        cur_y_q[idx] <= py_q;
        cur_z_q[idx] <= pz_q;
      end
    end
  end

  // Seen bits, frame flag and config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_seen_q    <= '0;
      prev_seen_q   <= '0;
      any_valid_q   <= 1'b0;
      speed_limit_q <= SPEED_LIMIT_RST;
    end else begin
      if (cfg_valid_i && cfg_ready_o) speed_limit_q <= cfg_data_i;
      if (fin_fire) begin
        if (op_q == OP_CLOSE) begin
          if (cur_seen_q != '0) prev_seen_q <= cur_seen_q;
          cur_seen_q  <= '0;
          any_valid_q <= 1'b0;
        end else begin
          if (in_range) cur_seen_q[idx] <= 1'b1;
          if (meas_ok) any_valid_q <= 1'b1;
        end
      end
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      is_close_q <= op_q;
      if (op_q == OP_CLOSE) begin
        out_id_q      <= 3'd0;
        vel_valid_q   <= 1'b0;
        vel_x_q       <= '0;
        vel_y_q       <= '0;
        vel_z_q       <= '0;
        speed_out_q   <= '0;
        frame_state_q <= any_valid_q;
      end else begin
        out_id_q      <= id_q;
        vel_valid_q   <= meas_ok;
        vel_x_q       <= meas_ok ? vel_q[0] : 32'sd0;
        vel_y_q       <= meas_ok ? vel_q[1] : 32'sd0;
        vel_z_q       <= meas_ok ? vel_q[2] : 32'sd0;
        speed_out_q   <= meas_ok ? speed_q : 32'd0;
        frame_state_q <= 1'b0;
      end
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign out_id_o      = out_id_q;
  assign is_close_o    = is_close_q;
  assign vel_valid_o   = vel_valid_q;
  assign vel_x_o       = vel_x_q;
  assign vel_y_o       = vel_y_q;
  assign vel_z_o       = vel_z_q;
  assign speed_o       = speed_out_q;
  assign frame_state_o = frame_state_q;

`ifndef SYNTHESIS
  // Unit never runs while the block takes new items
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    itu_rsp.busy |-> in_stall_o)
    else $error("iterative unit busy while input open");

  // Close results carry no velocity
  a_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_close_o) |-> (!vel_valid_o && speed_o == 32'd0))
    else $error("close result carries velocity");

  // A valid velocity is under the limit
  a_speed_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && vel_valid_o) |-> (speed_o < speed_limit_q))
    else $error("valid velocity at or above limit");
`endif

endmodule

/* hw/rtl/ove_itu.sv */
// ----------------------------------------------------------------------------
// ove_itu
// Shared shift-subtract unit: 64/20 bit restoring divide with 32 quotient
// bits and overflow flag, or 64 bit integer square root. 32 steps each.
// ----------------------------------------------------------------------------
module ove_itu
  import ove_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  itu_req_t    req_i,
  input  logic [63:0] num_i,
  input  logic [19:0] den_i,
  output itu_rsp_t    rsp_o,
  output logic [31:0] res_o
);

  logic        busy_q;
  logic        done_q;
  logic        ovf_q;
  itu_mode_e   mode_q;
  logic [4:0]  cnt_q;
  logic [63:0] acc_q;
  logic [63:0] res_q;
  logic [63:0] bit_q;

  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [64:0] diff;
  logic        ge;

  // Select operands of the one shared subtractor
  always_comb begin
    if (mode_q == ITU_DIV) begin
      op_a = {acc_q[62:0], res_q[31]};
      op_b = {44'd0, den_i};
    end else begin
      op_a = acc_q;
      op_b = res_q + bit_q;
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[64];
  end

  // Control: busy for 32 steps, pulse done after the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == 5'd31)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: load operands, then one step per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.mode;
      cnt_q  <= 5'd0;
      bit_q  <= 64'h4000_0000_0000_0000;
      if (req_i.mode == ITU_DIV) begin
        acc_q <= {32'd0, num_i[63:32]};
        res_q <= {32'd0, num_i[31:0]};
        ovf_q <= num_i[63:32] >= {12'd0, den_i};
      end else begin
        acc_q <= num_i;
        res_q <= 64'd0;
        ovf_q <= 1'b0;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (mode_q == ITU_DIV) begin
        acc_q <= ge ? diff[63:0] : op_a;
        res_q <= {res_q[62:0], ge};
      end else begin
        acc_q <= ge ? diff[63:0] : acc_q;
        res_q <= ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
        bit_q <= bit_q >> 2;
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign res_o      = res_q[31:0];

endmodule

/* verif/object_velocity_estimator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// object_velocity_estimator_test
// Drives detections and close-frame transactions into the velocity estimator,
// predicts each result with a behavioral copy of the tracker and compares the
// output field by field, with random bursts, gaps and output stalls.
// ----------------------------------------------------------------------------
module object_velocity_estimator_test;
  import ove_pkg::*;

  localparam int NOBJ = 5;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [2:0]         id;
    logic               close;
    logic               vvalid;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [31:0]        spd;
    logic               fstate;
  } vel_result_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, opcode_i;
  logic [2:0] object_id_i;
  logic signed [23:0] pos_x_i, pos_y_i, pos_z_i;
  logic [19:0] interval_us_i;
  logic out_valid_o, out_stall_i;
  logic [2:0] out_id_o;
  logic is_close_o, vel_valid_o, frame_state_o;
  logic signed [31:0] vel_x_o, vel_y_o, vel_z_o;
  logic [31:0] speed_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [31:0] cfg_data_i;

  object_velocity_estimator dut (.*);

  // Tracker state as predicted
  logic [31:0] lim_q;
  logic signed [23:0] prv_x [NOBJ], prv_y [NOBJ], prv_z [NOBJ];
  logic signed [23:0] cur_x [NOBJ], cur_y [NOBJ], cur_z [NOBJ];
  logic [NOBJ-1:0] prv_seen, cur_seen;
  logic frame_hit;
  vel_result_t pending_results[$];
  int errors;
  int cycles;
  int stall_mode;

  // Clock
  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Trip the run on a hang
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [31:0] axis_rate(longint d, int unsigned iv);
    longint unsigned mag, q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = mag * 64'd1000000 / iv;
    if (d < 0) return (q > 64'd2147483648) ? 32'sh80000000 : 32'(-longint'(q));
    return (q > 64'd2147483647) ? 32'sh7fffffff : 32'(q);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Work out the result of one transaction and advance the tracker
  function automatic vel_result_t track_item(logic op, logic [2:0] id,
      logic signed [23:0] px, logic signed [23:0] py, logic signed [23:0] pz,
      logic [19:0] iv);
    vel_result_t r;
    logic signed [31:0] vx, vy, vz;
    longint unsigned ax, ay, az, sp;
    r = '0;
    if (op == OP_CLOSE) begin
      r.close = 1'b1;
      r.fstate = frame_hit;
      if (cur_seen != '0) begin
        prv_x = cur_x; prv_y = cur_y; prv_z = cur_z;
        prv_seen = cur_seen;
      end
      cur_seen = '0;
      frame_hit = 1'b0;
      return r;
    end
    r.id = id;
    if (32'(id) < NOBJ) begin
      if (prv_seen[id] && iv != 20'd0) begin
        vx = axis_rate(longint'(px) - longint'(prv_x[id]), 32'(iv));
        vy = axis_rate(longint'(py) - longint'(prv_y[id]), 32'(iv));
        vz = axis_rate(longint'(pz) - longint'(prv_z[id]), 32'(iv));
        ax = (vx < 0) ? -longint'(vx) : longint'(vx);
        ay = (vy < 0) ? -longint'(vy) : longint'(vy);
        az = (vz < 0) ? -longint'(vz) : longint'(vz);
        sp = root_floor(ax * ax + ay * ay + az * az);
        if (sp < {32'd0, lim_q}) begin
          r.vvalid = 1'b1;
          r.vx = vx; r.vy = vy; r.vz = vz;
          r.spd = sp[31:0];
          frame_hit = 1'b1;
        end
      end
      cur_x[id] = px; cur_y[id] = py; cur_z[id] = pz;
      cur_seen[id] = 1'b1;
    end
    return r;
  endfunction

  // Output stall pattern, several modes incl. no stall
  always @(negedge clk_i) begin
    case (stall_mode)
      0: out_stall_i <= 0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    vel_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_id_o !== e.id) begin
          $error("out_id exp %0d got %0d", e.id, out_id_o); errors++;
        end
        if (is_close_o !== e.close) begin
          $error("is_close exp %0d got %0d", e.close, is_close_o); errors++;
        end
        if (vel_valid_o !== e.vvalid) begin
          $error("vel_valid exp %0d got %0d", e.vvalid, vel_valid_o); errors++;
        end
        if (vel_x_o !== e.vx) begin
          $error("vel_x exp %0d got %0d", e.vx, vel_x_o); errors++;
        end
        if (vel_y_o !== e.vy) begin
          $error("vel_y exp %0d got %0d", e.vy, vel_y_o); errors++;
        end
        if (vel_z_o !== e.vz) begin
          $error("vel_z exp %0d got %0d", e.vz, vel_z_o); errors++;
        end
        if (speed_o !== e.spd) begin
          $error("speed exp %0d got %0d", e.spd, speed_o); errors++;
        end
        if (frame_state_o !== e.fstate) begin
          $error("frame_state exp %0d got %0d", e.fstate, frame_state_o); errors++;
        end
      end
    end
  end

  // Send one transaction, hold until accepted
  task automatic send_item(logic op, logic [2:0] id, logic signed [23:0] px,
      logic signed [23:0] py, logic signed [23:0] pz, logic [19:0] iv);
    in_valid_i <= 1;
    opcode_i <= op; object_id_i <= id;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz; interval_us_i <= iv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(track_item(op, id, px, py, pz, iv));
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    in_valid_i <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  task automatic detect(int id, int px, int py, int pz, int iv);
    send_item(OP_DETECT, 3'(id), 24'(px), 24'(py), 24'(pz), 20'(iv));
  endtask

  task automatic close_frame();
    send_item(OP_CLOSE, 3'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              20'($urandom));
  endtask

  // Drain outputs, then let the block settle before a register write
  task automatic write_limit(logic [31:0] v);
    in_valid_i <= 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1; cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    lim_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Edge cases: extremes, ranges, zero interval, repeats, empty frames
  task automatic test_directed();
    stall_mode = 1;
    close_frame();                                 // empty frame first
    detect(0, 0, 0, 0, 1000);
    detect(1, 8388607, -8388608, 8388607, 1);
    detect(4, -8388608, 8388607, -8388608, 1000000);
    detect(7, 1, 2, 3, 5);                         // out of range
    detect(5, 1, 2, 3, 5);
    close_frame();
    detect(0, 10, 20, 30, 1000000);                // small speed
    detect(1, -8388608, 8388607, -8388608, 1);     // saturate
    detect(4, -8388608, 8388607, -8388608, 0);     // zero interval
    detect(0, 12, 20, 30, 1000000);                // same id twice
    idle_gap();
    close_frame();
    detect(6, 0, 0, 0, 100);                       // only bad ids
    close_frame();
    close_frame();                                 // empty: keep old set
    detect(0, 13, 21, 29, 1000000);
    detect(2, 5, 5, 5, 100);                       // not seen before
    close_frame();
  endtask

  task automatic test_limit_extremes();
    write_limit(32'hffffffff);
    detect(0, 8388607, 8388607, 8388607, 1);
    detect(1, 8388607, -8388608, 8388607, 1);
    close_frame();
    detect(1, -8388608, 8388607, -8388608, 1);
    detect(0, 0, 0, 0, 3);
    close_frame();
    write_limit(32'd0);
    detect(0, 1, 1, 1, 1000);
    close_frame();
    write_limit(32'd1);
    detect(0, 1, 1, 1, 1000);
    close_frame();
  endtask

  // Random frames: mostly well-formed with small motion, some noise
  task automatic run_frames(int n_items, logic [31:0] lim);
    int sent, k, idv;
    int burst;
    write_limit(lim);
    sent = 0;
    burst = $urandom_range(1, 12);
    while (sent < n_items) begin
      k = $urandom_range(1, 5);
      repeat (k) begin
        idv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 4);
        case ($urandom_range(0, 9))
          0: detect(idv, $urandom, $urandom, $urandom, $urandom_range(0, 1000000));
          1: detect(idv, $urandom, $urandom, $urandom, $urandom_range(0, 3));
          2: detect(idv, $urandom_range(0, 300), $urandom_range(0, 300),
                    $urandom_range(0, 300), $urandom_range(0, 2) == 0 ? 0 : 20'hfffff);
          default: detect(idv, $signed($urandom_range(0, 64)) - 32,
                          $signed($urandom_range(0, 64)) - 32,
                          $signed($urandom_range(0, 64)) - 32,
                          $urandom_range(30000, 40000));
        endcase
        sent++;
        if (--burst == 0) begin
          idle_gap();
          burst = $urandom_range(1, 12);
        end
      end
      close_frame();
      sent++;
      if ($urandom_range(0, 7) == 0) close_frame();
    end
  endtask

  task automatic test_random();
    stall_mode = 0; run_frames(160, 32'd800);
    stall_mode = 2; run_frames(160, 32'd2000);
    stall_mode = 3; run_frames(160, 32'd400);
    stall_mode = 1; run_frames(170, SPEED_LIMIT_RST);
  endtask

  initial begin
    errors = 0; cycles = 0; stall_mode = 0;
    in_valid_i = 0; opcode_i = 0; object_id_i = 0;
    pos_x_i = 0; pos_y_i = 0; pos_z_i = 0; interval_us_i = 0;
    out_stall_i = 0; cfg_valid_i = 0; cfg_data_i = 0;
    lim_q = SPEED_LIMIT_RST;
    prv_seen = 0; cur_seen = 0; frame_hit = 0;
    for (int i = 0; i < NOBJ; i++) begin
      prv_x[i] = 0; prv_y[i] = 0; prv_z[i] = 0;
      cur_x[i] = 0; cur_y[i] = 0; cur_z[i] = 0;
    end
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    test_directed();
    test_limit_extremes();
    test_random();
    in_valid_i <= 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/ove_pkg.sv
hw/rtl/ove_itu.sv
hw/rtl/object_velocity_estimator.sv
verif/object_velocity_estimator_test.sv
